/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the positional list engine.
// No dependencies; used by every module under rtl/core.
package ple_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int POS_W        = 16;
    localparam int VAL_W        = 32;
    localparam int OUT_W        = 9;
    localparam int RADIX_W      = 4;   // reduction tree takes 16 children per node

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] result_value;
        logic [OUT_W-1:0]        found_position;
        logic [OUT_W-1:0]        list_length;
        logic                    is_empty;
    } t_out_item;

    // broadcast to every cell on an accepted item
    typedef struct packed {
        logic                    go;
        logic                    ins;
        logic                    del;
        logic                    rd;
        logic                    loc;
        logic [POS_W-1:0]        pos_m1;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        lim;
    } t_cell_ctl;

endpackage

/* rtl/core/ple_cell.sv */
`timescale 1ns / 1ps
// One list slot: holds an element, shifts up or down with its neighbors,
// and flags a position or value match. Depends on ple_pkg.
module ple_cell (
    input  logic                             i_clk,
    input  logic [ple_pkg::POS_W-1:0]        i_idx,
    input  ple_pkg::t_cell_ctl               i_ctl,
    input  logic signed [ple_pkg::VAL_W-1:0] i_left,
    input  logic signed [ple_pkg::VAL_W-1:0] i_right,
    output logic signed [ple_pkg::VAL_W-1:0] o_data,
    output logic                             o_hit,
    output logic signed [ple_pkg::VAL_W-1:0] o_tap
);
    import ple_pkg::*;

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] r_tap;
    logic                    r_hit;
    logic                    at_pos;
    logic                    from_pos;
    logic                    live;

    assign at_pos   = (i_idx == i_ctl.pos_m1);
    assign from_pos = (i_idx >= i_ctl.pos_m1);
    assign live     = (i_idx < i_ctl.lim);

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_hit <= (i_ctl.rd && at_pos) || (i_ctl.loc && live && (r_data == i_ctl.value));
            r_tap <= r_data;   // value before any shift, for get and delete
        end
        if (i_ctl.ins && from_pos) begin
            r_data <= at_pos ? i_ctl.value : i_left;
        end else if (i_ctl.del && from_pos) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_tap  = r_tap;

endmodule

/* rtl/core/ple_tree.sv */
`timescale 1ns / 1ps
// Registered 16-way priority reduction over the cell flags: lowest flagged
// cell wins, giving its index and value. Depends on ple_pkg.
module ple_tree #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY,
    parameter int LVLS     = 2,
    parameter int IDXW     = 8
) (
    input  logic                             i_clk,
    input  logic [CAPACITY-1:0]              i_hit,
    input  logic signed [ple_pkg::VAL_W-1:0] i_val [CAPACITY],
    output logic                             o_hit,
    output logic [IDXW-1:0]                  o_idx,
    output logic signed [ple_pkg::VAL_W-1:0] o_val
);
    import ple_pkg::*;

    localparam int FAN    = 1 << RADIX_W;
    localparam int LEAVES = 1 << (RADIX_W * LVLS);
    localparam int NODES  = LEAVES / FAN;

    logic                    leaf_hit [LEAVES];
    logic signed [VAL_W-1:0] leaf_val [LEAVES];

    logic                    r_hit [LVLS][NODES];
    logic [IDXW-1:0]         r_idx [LVLS][NODES];
    logic signed [VAL_W-1:0] r_val [LVLS][NODES];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < CAPACITY) begin : g_real
            assign leaf_hit[i] = i_hit[i];
            assign leaf_val[i] = i_val[i];
        end else begin : g_pad
            assign leaf_hit[i] = 1'b0;
            assign leaf_val[i] = '0;
        end
    end

    for (genvar l = 0; l < LVLS; l++) begin : g_lvl
        localparam int NN = LEAVES >> (RADIX_W * (l + 1));
        for (genvar j = 0; j < NODES; j++) begin : g_node
            if (j < NN) begin : g_used
                logic                    c_hit [FAN];
                logic [IDXW-1:0]         c_idx [FAN];
                logic signed [VAL_W-1:0] c_val [FAN];
                logic [RADIX_W-1:0]      sel;
                logic                    any;

                for (genvar c = 0; c < FAN; c++) begin : g_child
                    if (l == 0) begin : g_src_leaf
                        assign c_hit[c] = leaf_hit[j*FAN + c];
                        assign c_idx[c] = '0;
                        assign c_val[c] = leaf_val[j*FAN + c];
                    end else begin : g_src_node
                        assign c_hit[c] = r_hit[l-1][j*FAN + c];
                        assign c_idx[c] = r_idx[l-1][j*FAN + c];
                        assign c_val[c] = r_val[l-1][j*FAN + c];
                    end
                end

                always_comb begin
                    sel = '0;
                    any = 1'b0;
                    for (int c = FAN - 1; c >= 0; c--) begin
                        if (c_hit[c]) begin
                            sel = RADIX_W'(c);
                            any = 1'b1;
                        end
                    end
                end

                always_ff @(posedge i_clk) begin
                    r_hit[l][j] <= any;
                    r_idx[l][j] <= c_idx[sel] | (IDXW'(sel) << (RADIX_W * l));
                    r_val[l][j] <= c_val[sel];
                end
            end else begin : g_unused
                always_ff @(posedge i_clk) begin
                    r_hit[l][j] <= 1'b0;
                    r_idx[l][j] <= '0;
                    r_val[l][j] <= '0;
                end
            end
        end
    end

    assign o_hit = r_hit[LVLS-1][0];
    assign o_idx = r_idx[LVLS-1][0];
    assign o_val = r_val[LVLS-1][0];

endmodule

/* rtl/core/positional_list_engine.sv */
`timescale 1ns / 1ps
// Positional list engine top level: control, element cells and match tree.
// Depends on ple_pkg, ple_cell and ple_tree.
//
// An item is taken when start is high and busy is low. Its single result is
// on o_result for exactly one cycle with o_done high, once the cell flags
// have passed through the registered levels of the tree; the result is taken
// at the edge that ends that cycle. LVLS = ceil(log16(CAPACITY)), which is 2
// at 256 entries. The insert/delete shift happens at the accept edge in every
// cell from the given position up. The latency comes from the registered
// 16-way reduction tree that picks the matching cell for get, delete and
// locate. busy drops in the result cycle, so a new item can be taken at the
// edge that delivers a result, and not before. There is no back-pressure on
// results. Element storage needs no clearing after reset.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ple_pkg::t_in_item  i_item,
    output logic               o_done,
    output ple_pkg::t_out_item o_result
);
    import ple_pkg::*;

    localparam int LVLS  = ($clog2(CAPACITY) + RADIX_W - 1) / RADIX_W;
    localparam int IDXW  = RADIX_W * LVLS;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int STEPW = $clog2(LVLS + 1);

    logic                    r_busy;
    logic [STEPW-1:0]        r_step;
    logic [CW-1:0]           r_count;
    t_status                 r_status;
    logic                    r_rd;
    logic                    r_loc;

    logic [CW-1:0]           n_count;
    t_status                 n_status;
    logic                    n_ins;
    logic                    n_del;
    logic                    n_rd;
    logic                    n_loc;

    logic                    accept;
    logic                    done;
    logic                    pos_nz;
    logic                    ins_ok;
    logic                    rd_ok;
    logic [POS_W:0]          pos_x;
    logic [POS_W:0]          cnt_x;
    t_cell_ctl               ctl;

    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic signed [VAL_W-1:0] cell_tap  [CAPACITY];
    logic [CAPACITY-1:0]     cell_hit;

    logic                    tree_hit;
    logic [IDXW-1:0]         tree_idx;
    logic signed [VAL_W-1:0] tree_val;
    logic [IDXW:0]           found_x;

    assign done   = r_busy && (r_step == STEPW'(LVLS));
    assign busy   = r_busy && !done;
    assign accept = start && !busy;

    assign pos_x  = {1'b0, i_item.position};
    assign cnt_x  = (POS_W + 1)'(r_count);
    assign pos_nz = (i_item.position != '0);
    assign ins_ok = pos_nz && (pos_x <= cnt_x + 1'b1);
    assign rd_ok  = pos_nz && (pos_x <= cnt_x);

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        n_ins    = 1'b0;
        n_del    = 1'b0;
        n_rd     = 1'b0;
        n_loc    = 1'b0;
        case (i_item.opcode)
            OP_INSERT: begin
                if (!ins_ok) begin
                    n_status = ST_RANGE;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (!rd_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_del   = 1'b1;
                    n_rd    = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_GET: begin
                if (!rd_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = 1'b1;
                end
            end
            OP_LOCATE: begin
                n_loc = 1'b1;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctl.go     = accept;
        ctl.ins    = accept && n_ins;
        ctl.del    = accept && n_del;
        ctl.rd     = accept && n_rd;
        ctl.loc    = accept && n_loc;
        ctl.pos_m1 = i_item.position - 1'b1;
        ctl.value  = i_item.value;
        ctl.lim    = POS_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_step  <= '0;
            r_count <= n_count;
        end else if (r_busy) begin
            if (done) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_loc    <= n_loc;
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[k];
        end else begin : g_mid_r
            assign right_d = cell_data[k+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (POS_W'(k)),
            .i_ctl   (ctl),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[k]),
            .o_hit   (cell_hit[k]),
            .o_tap   (cell_tap[k])
        );
    end

    ple_tree #(
        .CAPACITY (CAPACITY),
        .LVLS     (LVLS),
        .IDXW     (IDXW)
    ) u_tree (
        .i_clk (i_clk),
        .i_hit (cell_hit),
        .i_val (cell_tap),
        .o_hit (tree_hit),
        .o_idx (tree_idx),
        .o_val (tree_val)
    );

    assign found_x = (IDXW + 1)'(tree_idx) + 1'b1;

    always_comb begin
        o_result.status         = r_status;
        o_result.result_value   = r_rd ? tree_val : '0;
        o_result.found_position = (r_loc && tree_hit) ? OUT_W'(found_x) : '0;
        o_result.list_length    = OUT_W'(r_count);
        o_result.is_empty       = (r_count == '0);
    end

    assign o_done = done;

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not hold busy");

    a_single_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine: queued items, bursty driver,
// result monitor checked against an in-bench list model. Depends on ple_pkg and the RTL.
module tb;
    import ple_pkg::*;

    localparam int LIST_CAP    = DEF_CAPACITY;
    localparam int RAND_ITEMS  = 1600;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK, MIX_READ} t_mix;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    positional_list_engine #(.CAPACITY(LIST_CAP)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // list model used to predict each result
    logic signed [VAL_W-1:0] list_mem [LIST_CAP];
    int                      list_len = 0;

    t_in_item  item_queue [$];
    t_out_item results_due [$];
    int        items_queued   = 0;
    int        items_accepted = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    // generator side: tracks only the length so positions can be aimed
    int                      gen_len = 0;
    logic signed [VAL_W-1:0] val_pool [8];

    function automatic t_out_item apply_list_op(t_in_item it);
        t_out_item r;
        int        p;
        int        k;
        int        found;
        r     = '0;
        p     = int'(it.position);
        found = 0;
        case (it.opcode)
            OP_INSERT: begin
                if (p == 0 || p > list_len + 1) begin
                    r.status = ST_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = list_len; k > p - 1; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = it.value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p == 0 || p > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.result_value = list_mem[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            OP_GET: begin
                if (p == 0 || p > list_len)
                    r.status = ST_RANGE;
                else
                    r.result_value = list_mem[p-1];
            end
            OP_LOCATE: begin
                for (k = 0; k < list_len && found == 0; k++)
                    if (list_mem[k] == it.value)
                        found = k + 1;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: ;
        endcase
        r.found_position = OUT_W'(found);
        r.list_length    = OUT_W'(list_len);
        r.is_empty       = (list_len == 0);
        return r;
    endfunction

    task automatic add_item(logic [2:0] op, int pos, logic signed [VAL_W-1:0] val);
        t_in_item it;
        it.opcode   = op;
        it.position = POS_W'(pos);
        it.value    = val;
        item_queue.push_back(it);
        items_queued++;
        case (op)
            OP_INSERT:
                if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
            OP_DELETE:
                if (pos >= 1 && pos <= gen_len) gen_len--;
            OP_CLEAR:
                gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic int pick_position(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 78 && lim > 0) return $urandom_range(1, lim);
        if (r < 84) return 0;
        if (r < 90) return lim + 1;
        if (r < 94) return 65535;
        if (r < 97 && lim > 0) return lim;
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0) return val_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic add_random_item(t_mix mix);
        int th [5];
        int r;
        case (mix)
            MIX_GROW:   th = '{70, 78, 86, 95, 96};
            MIX_SHRINK: th = '{10, 65, 78, 92, 94};
            MIX_READ:   th = '{15, 25, 60, 95, 96};
            default:    th = '{30, 50, 68, 88, 90};
        endcase
        r = $urandom_range(0, 99);
        if (r < th[0])      add_item(OP_INSERT, pick_position(gen_len + 1), pick_value());
        else if (r < th[1]) add_item(OP_DELETE, pick_position(gen_len), pick_value());
        else if (r < th[2]) add_item(OP_GET, pick_position(gen_len), pick_value());
        else if (r < th[3]) add_item(OP_LOCATE, pick_position(gen_len), pick_value());
        else if (r < th[4]) add_item(OP_CLEAR, pick_position(gen_len), pick_value());
        // opcodes past clear change nothing in the block but still return a result
        else add_item(3'(OP_CLEAR) + 3'($urandom_range(1, 3)), $urandom_range(0, 65535),
                      $urandom);
    endtask

    task automatic report_mismatch(string what, t_out_item exp, t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t %s: exp st=%0d val=%0d fnd=%0d len=%0d emp=%0b",
                   $realtime, what, exp.status, exp.result_value, exp.found_position,
                   exp.list_length, exp.is_empty);
            $display(" | got st=%0d val=%0d fnd=%0d len=%0d emp=%0b",
                     got.status, got.result_value, got.found_position,
                     got.list_length, got.is_empty);
        end
    endtask

    // driver: bursts of items with random gaps between them
    int   burst_left = 0;
    int   gap_left   = 0;
    logic drv_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_hold = start;
            if (start && !busy) begin
                results_due.push_back(apply_list_op(i_item));
                items_accepted++;
                drv_hold = 1'b0;
            end
            if (!drv_hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_queue.size() > 0) begin
                    i_item <= item_queue.pop_front();
                    drv_hold = 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                                 : $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            start <= drv_hold;
        end
    end

    // monitor: results cannot be held off, check every strobe
    t_out_item due;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with none pending", '0, o_result);
            end else begin
                due = results_due.pop_front();
                if (o_result.status !== due.status ||
                    o_result.result_value !== due.result_value ||
                    o_result.found_position !== due.found_position ||
                    o_result.list_length !== due.list_length ||
                    o_result.is_empty !== due.is_empty)
                    report_mismatch("mismatch", due, o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    int   rand_count;
    t_mix mix;
    int   seg_len;
    int   k;

    initial begin
        val_pool[0] = 32'sh8000_0000;
        val_pool[1] = 32'sh7fff_ffff;
        val_pool[2] = 32'sh0;
        val_pool[3] = -32'sd1;
        for (k = 4; k < 8; k++)
            val_pool[k] = $urandom;

        // directed: empty list, bad positions, front/middle/back inserts, duplicates
        add_item(OP_GET, 1, 0);
        add_item(OP_DELETE, 1, 0);
        add_item(OP_LOCATE, 0, 0);
        add_item(OP_INSERT, 0, 5);
        add_item(OP_INSERT, 2, 5);
        add_item(OP_INSERT, 1, val_pool[0]);
        add_item(OP_INSERT, 2, val_pool[1]);
        add_item(OP_INSERT, 1, -32'sd1);
        add_item(OP_INSERT, 2, 0);
        add_item(OP_INSERT, 5, val_pool[1]);
        add_item(OP_LOCATE, 0, val_pool[1]);
        add_item(OP_LOCATE, 3, 32'sd12345);
        add_item(OP_GET, 5, 0);
        add_item(OP_GET, 6, 0);
        add_item(OP_GET, 65535, 0);
        add_item(OP_DELETE, 65535, 0);
        add_item(OP_DELETE, 2, 0);
        add_item(3'(OP_CLEAR) + 3'd1, 1, -32'sd1);
        add_item(3'(OP_CLEAR) + 3'd2, 65535, 32'sh7fff_ffff);
        add_item(3'(OP_CLEAR) + 3'd3, 2, 32'sh8000_0000);
        add_item(OP_DELETE, 4, 0);
        add_item(OP_DELETE, 1, 0);
        add_item(OP_CLEAR, 0, 0);
        add_item(OP_GET, 1, 0);

        // fill to capacity, then poke the full list
        for (k = 0; k < LIST_CAP; k++)
            add_item(OP_INSERT, $urandom_range(1, gen_len + 1), pick_value());
        add_item(OP_INSERT, 1, 7);
        add_item(OP_INSERT, LIST_CAP + 1, 7);
        add_item(OP_INSERT, 0, 7);
        add_item(OP_INSERT, LIST_CAP + 2, 7);
        add_item(OP_LOCATE, 0, val_pool[1]);
        add_item(OP_LOCATE, 0, val_pool[5]);
        add_item(OP_GET, LIST_CAP, 0);
        add_item(OP_GET, LIST_CAP + 1, 0);
        add_item(OP_DELETE, LIST_CAP, 0);
        add_item(OP_INSERT, LIST_CAP, val_pool[3]);
        add_item(OP_INSERT, LIST_CAP, val_pool[2]);
        add_item(OP_DELETE, 1, 0);

        // random segments, each balanced or biased toward growing, draining or reading
        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 120);
            repeat (seg_len) begin
                add_random_item(mix);
                if (item_queue[$].opcode <= OP_CLEAR) rand_count++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < items_queued || results_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_tree.sv
rtl/core/positional_list_engine.sv
sim/tb.sv
